FILE: rtl/tdav_pkg.sv
package tdav_pkg;

    // Field widths
    localparam int STATE_W  = 8;
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 16;
    localparam int TD_W     = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Item opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Bootstrap modes
    localparam logic MODE_QLEARN = 1'b0;
    localparam logic MODE_SARSA  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] LEARN_RATE_RST = 16'd6554;
    localparam logic [CFG_W-1:0] DISCOUNT_RST   = 16'd62259;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_ADDR,
        ST_RD_OLD,
        ST_RD_BOOT,
        ST_DRAIN,
        ST_DISC,
        ST_TD,
        ST_STEP,
        ST_NEW,
        ST_RESULT
    } state_t;

    // Datapath strobes from the sequencer
    typedef struct packed {
        logic cap_old;
        logic cap_boot_first;
        logic cap_boot_max;
        logic do_disc;
        logic do_td;
        logic do_step;
        logic do_new;
    } dp_ctl_t;

endpackage

FILE: rtl/tdav_in_if.sv
interface tdav_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [tdav_pkg::STATE_W-1:0]        prev_state;
    logic [tdav_pkg::ACTION_W-1:0]       prev_action;
    logic signed [tdav_pkg::VALUE_W-1:0] reward;
    logic [tdav_pkg::STATE_W-1:0]        next_state;
    logic [tdav_pkg::ACTION_W-1:0]       next_action;

    modport source (
        output valid, op, prev_state, prev_action, reward, next_state, next_action,
        input  ready
    );

    modport sink (
        input  valid, op, prev_state, prev_action, reward, next_state, next_action,
        output ready
    );
endinterface

FILE: rtl/tdav_out_if.sv
interface tdav_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tdav_pkg::VALUE_W-1:0] new_value;
    logic signed [tdav_pkg::TD_W-1:0]    td_error;

    modport source (
        output valid, new_value, td_error,
        input  ready
    );

    modport sink (
        input  valid, new_value, td_error,
        output ready
    );
endinterface

FILE: rtl/td_action_value_table_update_unit.sv
// Tabular Q-learning / SARSA value updater. The STATES x ACTIONS table of signed Q8.8
// values sits in one single-port-read, single-port-write memory, and each item is
// handled alone by a sequencer that reads, computes and writes back. An update is
// paced by the one memory read port: the old entry and then, in Q-learning mode,
// every action of the next state, or in SARSA mode only the next pair, are read one
// per cycle before two registered multiplies and the write. A clear item sweeps the
// table one entry per cycle. After reset the same sweep writes zeros through the
// table, during which no item is accepted; configuration writes are taken at any
// time. A finished result waits in an output register without holding back the
// next item's processing up to its write-back.
module td_action_value_table_update_unit #(
    parameter int STATES  = 256,
    parameter int ACTIONS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tdav_in_if.sink                            item,
    tdav_out_if.source                         result,
    input  logic                               cfg_we,
    input  logic [tdav_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdav_pkg::CFG_W-1:0]         cfg_data
);

    localparam int DEPTH = STATES * ACTIONS;
    localparam int ADW   = $clog2(DEPTH);
    localparam int SW    = $clog2(STATES);
    localparam int AW    = $clog2(ACTIONS);

    tdav_pkg::state_t  state_reg;
    tdav_pkg::state_t  state_next;

    // Configuration registers
    logic                                mode_reg;
    logic [tdav_pkg::CFG_W-1:0]          learn_rate_reg;
    logic [tdav_pkg::CFG_W-1:0]          discount_reg;
    logic signed [tdav_pkg::VALUE_W-1:0] init_value_reg;

    // Item context
    logic                                op_reg;
    logic signed [tdav_pkg::VALUE_W-1:0] fill_reg;
    logic signed [tdav_pkg::VALUE_W-1:0] reward_reg;
    logic [SW-1:0]                       ps_reg;
    logic [AW-1:0]                       pa_reg;
    logic [SW-1:0]                       ns_reg;
    logic [AW-1:0]                       na_reg;
    logic [ADW-1:0]                      old_addr_reg;
    logic [ADW-1:0]                      base_addr_reg;
    logic [ADW-1:0]                      sarsa_addr_reg;
    logic [ADW-1:0]                      clr_cnt_reg;
    logic [AW-1:0]                       act_cnt_reg;
    tdav_pkg::dp_ctl_t                   cap_reg;
    tdav_pkg::dp_ctl_t                   cap_next;

    // Reduced indexes
    logic [SW-1:0] ps_rem;
    logic [AW-1:0] pa_rem;
    logic [SW-1:0] ns_rem;
    logic [AW-1:0] na_rem;

    // Memory and datapath
    logic                                mem_we;
    logic [ADW-1:0]                      mem_waddr;
    logic signed [tdav_pkg::VALUE_W-1:0] mem_wdata;
    logic [ADW-1:0]                      mem_raddr;
    logic signed [tdav_pkg::VALUE_W-1:0] mem_rdata;
    tdav_pkg::dp_ctl_t                   dp_ctl;
    logic signed [tdav_pkg::VALUE_W-1:0] dp_new_value;
    logic signed [tdav_pkg::TD_W-1:0]    dp_td_error;

    // Output register
    logic                                out_valid_reg;
    logic signed [tdav_pkg::VALUE_W-1:0] out_value_reg;
    logic signed [tdav_pkg::TD_W-1:0]    out_td_reg;

    logic item_xfer;
    logic out_free;
    logic out_load;
    logic clr_last;
    logic boot_last;

    assign item_xfer = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign clr_last  = (clr_cnt_reg == ADW'(DEPTH - 1));
    assign boot_last = (mode_reg == tdav_pkg::MODE_SARSA) || (act_cnt_reg == AW'(ACTIONS - 1));

    // Index reduction modulo the table dimensions
    tdav_idx_mod #(.DIV(STATES), .W(tdav_pkg::STATE_W), .OW(SW)) u_ps_mod (
        .clk  (clk),
        .load (item_xfer),
        .x    (item.prev_state),
        .rem  (ps_rem)
    );

    tdav_idx_mod #(.DIV(ACTIONS), .W(tdav_pkg::ACTION_W), .OW(AW)) u_pa_mod (
        .clk  (clk),
        .load (item_xfer),
        .x    (item.prev_action),
        .rem  (pa_rem)
    );

    tdav_idx_mod #(.DIV(STATES), .W(tdav_pkg::STATE_W), .OW(SW)) u_ns_mod (
        .clk  (clk),
        .load (item_xfer),
        .x    (item.next_state),
        .rem  (ns_rem)
    );

    tdav_idx_mod #(.DIV(ACTIONS), .W(tdav_pkg::ACTION_W), .OW(AW)) u_na_mod (
        .clk  (clk),
        .load (item_xfer),
        .x    (item.next_action),
        .rem  (na_rem)
    );

    tdav_value_mem #(.DEPTH(DEPTH), .ADW(ADW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tdav_datapath u_dp (
        .clk           (clk),
        .ctl           (dp_ctl),
        .rd_data       (mem_rdata),
        .reward        (reward_reg),
        .learning_rate (learn_rate_reg),
        .discount      (discount_reg),
        .new_value     (dp_new_value),
        .td_error      (dp_td_error)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= tdav_pkg::MODE_QLEARN;
            learn_rate_reg <= tdav_pkg::LEARN_RATE_RST;
            discount_reg   <= tdav_pkg::DISCOUNT_RST;
            init_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tdav_pkg::CFG_MODE:       mode_reg       <= cfg_data[0];
                tdav_pkg::CFG_LEARN_RATE: learn_rate_reg <= cfg_data;
                tdav_pkg::CFG_DISCOUNT:   discount_reg   <= cfg_data;
                tdav_pkg::CFG_INIT_VALUE: init_value_reg <= cfg_data;
                default:                  mode_reg       <= mode_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdav_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = (op_reg == tdav_pkg::OP_CLEAR) ? tdav_pkg::ST_RESULT
                                                                 : tdav_pkg::ST_IDLE;
                end
            end
            tdav_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = (item.op == tdav_pkg::OP_CLEAR) ? tdav_pkg::ST_CLEAR
                                                                  : tdav_pkg::ST_INDEX;
                end
            end
            tdav_pkg::ST_INDEX:   state_next = tdav_pkg::ST_ADDR;
            tdav_pkg::ST_ADDR:    state_next = tdav_pkg::ST_RD_OLD;
            tdav_pkg::ST_RD_OLD:  state_next = tdav_pkg::ST_RD_BOOT;
            tdav_pkg::ST_RD_BOOT:
            begin
                if (boot_last)
                begin
                    state_next = tdav_pkg::ST_DRAIN;
                end
            end
            tdav_pkg::ST_DRAIN:   state_next = tdav_pkg::ST_DISC;
            tdav_pkg::ST_DISC:    state_next = tdav_pkg::ST_TD;
            tdav_pkg::ST_TD:      state_next = tdav_pkg::ST_STEP;
            tdav_pkg::ST_STEP:    state_next = tdav_pkg::ST_NEW;
            tdav_pkg::ST_NEW:     state_next = tdav_pkg::ST_RESULT;
            tdav_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = tdav_pkg::ST_IDLE;
                end
            end
            default:              state_next = tdav_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        item.ready = (state_reg == tdav_pkg::ST_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = old_addr_reg;
        mem_wdata  = dp_new_value;
        mem_raddr  = old_addr_reg;
        out_load   = 1'b0;
        cap_next   = '0;
        dp_ctl     = cap_reg;

        case (state_reg)
            tdav_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = fill_reg;
            end
            tdav_pkg::ST_RD_OLD:
            begin
                cap_next.cap_old = 1'b1;
            end
            tdav_pkg::ST_RD_BOOT:
            begin
                if (mode_reg == tdav_pkg::MODE_SARSA)
                begin
                    mem_raddr = sarsa_addr_reg;
                end
                else
                begin
                    mem_raddr = base_addr_reg + ADW'(act_cnt_reg);
                end
                cap_next.cap_boot_first = (act_cnt_reg == '0);
                cap_next.cap_boot_max   = (act_cnt_reg != '0);
            end
            tdav_pkg::ST_DISC: dp_ctl.do_disc = 1'b1;
            tdav_pkg::ST_TD:   dp_ctl.do_td   = 1'b1;
            tdav_pkg::ST_STEP: dp_ctl.do_step = 1'b1;
            tdav_pkg::ST_NEW:  dp_ctl.do_new  = 1'b1;
            tdav_pkg::ST_RESULT:
            begin
                out_load = out_free;
                mem_we   = out_free && (op_reg == tdav_pkg::OP_UPDATE);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tdav_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            act_cnt_reg <= '0;
            op_reg      <= tdav_pkg::OP_UPDATE;
            fill_reg    <= '0;
            cap_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;

            // Start a sweep on a clear item, advance it while clearing
            if (item_xfer)
            begin
                op_reg      <= item.op;
                fill_reg    <= init_value_reg;
                clr_cnt_reg <= '0;
            end
            else if (state_reg == tdav_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            // Step through the next state's actions
            if (state_reg == tdav_pkg::ST_RD_OLD)
            begin
                act_cnt_reg <= '0;
            end
            else if (state_reg == tdav_pkg::ST_RD_BOOT)
            begin
                act_cnt_reg <= act_cnt_reg + 1'b1;
            end
        end
    end

    // Item payload and table addresses
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            reward_reg <= item.reward;
        end
        if (state_reg == tdav_pkg::ST_INDEX)
        begin
            ps_reg <= ps_rem;
            pa_reg <= pa_rem;
            ns_reg <= ns_rem;
            na_reg <= na_rem;
        end
        if (state_reg == tdav_pkg::ST_ADDR)
        begin
            old_addr_reg   <= ADW'(ps_reg * ACTIONS) + ADW'(pa_reg);
            base_addr_reg  <= ADW'(ns_reg * ACTIONS);
            sarsa_addr_reg <= ADW'(ns_reg * ACTIONS) + ADW'(na_reg);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (op_reg == tdav_pkg::OP_CLEAR)
            begin
                out_value_reg <= fill_reg;
                out_td_reg    <= '0;
            end
            else
            begin
                out_value_reg <= dp_new_value;
                out_td_reg    <= dp_td_error;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.new_value = out_value_reg;
    assign result.td_error  = out_td_reg;

    // Table writes come only from the sweep or the write-back
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == tdav_pkg::ST_CLEAR || state_reg == tdav_pkg::ST_RESULT))
        else $error("table write outside sweep or write-back");

    // Write-back and result load go together for an update
    a_wb_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdav_pkg::ST_RESULT && op_reg == tdav_pkg::OP_UPDATE)
        |-> (mem_we == out_load))
        else $error("write-back and result load out of step");

    // An accepted item starts either a sweep or index reduction
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> (state_reg == tdav_pkg::ST_CLEAR || state_reg == tdav_pkg::ST_INDEX))
        else $error("accepted item not started");

    // A clear result carries a zero TD error
    a_clear_td_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && op_reg == tdav_pkg::OP_CLEAR) |=> (out_td_reg == '0))
        else $error("clear result with nonzero TD error");

endmodule

FILE: rtl/tdav_idx_mod.sv
module tdav_idx_mod #(
    parameter int DIV = 256,
    parameter int W   = 8,
    parameter int OW  = 8
) (
    input  logic          clk,
    input  logic          load,
    input  logic [W-1:0]  x,
    output logic [OW-1:0] rem
);

    generate
        if (DIV >= (1 << W)) begin : g_pass
            logic [W-1:0] x_reg;

            // Hold the raw index; it is already in range
            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    x_reg <= x;
                end
            end

            assign rem = OW'(x_reg);
        end else begin : g_recip
            localparam int K = 2 * W;
            localparam logic [2*W-1:0] RECIP = (2**K + DIV - 1) / DIV;

            logic [W-1:0]   x_reg;
            logic [W-1:0]   q_reg;
            logic [3*W-1:0] prod;
            logic [W-1:0]   qd;
            logic [W-1:0]   r;

            // Quotient by reciprocal multiply, exact for all W-bit inputs
            assign prod = x * RECIP;

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    x_reg <= x;
                    q_reg <= prod[3*W-1:K];
                end
            end

            // Remainder from the registered quotient
            assign qd  = W'(q_reg * DIV);
            assign r   = x_reg - qd;
            assign rem = r[OW-1:0];
        end
    endgenerate

endmodule

FILE: rtl/tdav_value_mem.sv
module tdav_value_mem #(
    parameter int DEPTH = 2048,
    parameter int ADW   = 11
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [ADW-1:0]                      waddr,
    input  logic signed [tdav_pkg::VALUE_W-1:0] wdata,
    input  logic [ADW-1:0]                      raddr,
    output logic signed [tdav_pkg::VALUE_W-1:0] rdata
);

    logic [tdav_pkg::VALUE_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/tdav_datapath.sv
module tdav_datapath (
    input  logic                                clk,
    input  tdav_pkg::dp_ctl_t                   ctl,
    input  logic signed [tdav_pkg::VALUE_W-1:0] rd_data,
    input  logic signed [tdav_pkg::VALUE_W-1:0] reward,
    input  logic [tdav_pkg::CFG_W-1:0]          learning_rate,
    input  logic [tdav_pkg::CFG_W-1:0]          discount,
    output logic signed [tdav_pkg::VALUE_W-1:0] new_value,
    output logic signed [tdav_pkg::TD_W-1:0]    td_error
);

    logic signed [15:0] old_reg;
    logic signed [15:0] boot_reg;
    logic signed [32:0] disc_prod_reg;
    logic signed [16:0] td_reg;
    logic signed [33:0] step_prod_reg;
    logic signed [15:0] nv_reg;

    logic signed [32:0] disc_rnd;
    logic signed [16:0] disc;
    logic signed [18:0] td_raw;
    logic signed [16:0] td_sat;
    logic signed [33:0] step_rnd;
    logic signed [17:0] step;
    logic signed [18:0] nv_raw;
    logic signed [15:0] nv_sat;

    // Round discounted bootstrap to Q8.8, ties toward plus infinity
    assign disc_rnd = disc_prod_reg + 33'sd32768;
    assign disc     = disc_rnd[32:16];

    // TD error, saturated to 17 bits
    assign td_raw = reward + disc - old_reg;

    always_comb
    begin
        if (td_raw > 19'sd65535)
        begin
            td_sat = 17'sh0FFFF;
        end
        else if (td_raw < -19'sd65536)
        begin
            td_sat = 17'sh10000;
        end
        else
        begin
            td_sat = td_raw[16:0];
        end
    end

    // Round the step and add it to the old entry
    assign step_rnd = step_prod_reg + 34'sd32768;
    assign step     = step_rnd[33:16];
    assign nv_raw   = old_reg + step;

    always_comb
    begin
        if (nv_raw > 19'sd32767)
        begin
            nv_sat = 16'sh7FFF;
        end
        else if (nv_raw < -19'sd32768)
        begin
            nv_sat = 16'sh8000;
        end
        else
        begin
            nv_sat = nv_raw[15:0];
        end
    end

    // Capture read data and advance the arithmetic one step per strobe
    always_ff @(posedge clk)
    begin
        if (ctl.cap_old)
        begin
            old_reg <= rd_data;
        end
        if (ctl.cap_boot_first)
        begin
            boot_reg <= rd_data;
        end
        else if (ctl.cap_boot_max && (rd_data > boot_reg))
        begin
            boot_reg <= rd_data;
        end
        if (ctl.do_disc)
        begin
            disc_prod_reg <= $signed({1'b0, discount}) * boot_reg;
        end
        if (ctl.do_td)
        begin
            td_reg <= td_sat;
        end
        if (ctl.do_step)
        begin
            step_prod_reg <= $signed({1'b0, learning_rate}) * td_reg;
        end
        if (ctl.do_new)
        begin
            nv_reg <= nv_sat;
        end
    end

    assign new_value = nv_reg;
    assign td_error  = td_reg;

endmodule

FILE: bench/td_action_value_table_update_unit_tb.sv
module td_action_value_table_update_unit_tb;

    import tdav_pkg::*;

    localparam int TBL_STATES   = 256;
    localparam int TBL_ACTIONS  = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int N_PHASES     = 6;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic                       op;
        logic [STATE_W-1:0]         ps;
        logic [ACTION_W-1:0]        pa;
        logic signed [VALUE_W-1:0]  reward;
        logic [STATE_W-1:0]         ns;
        logic [ACTION_W-1:0]        na;
    } td_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  nv;
        logic signed [TD_W-1:0]     td;
    } td_result_t;

    typedef struct packed {
        row_kind_t                  kind;
        td_item_t                   it;
        logic [CFG_IDX_W-1:0]       cfg_idx;
        logic [CFG_W-1:0]           cfg_val;
        logic                       has_exp;
        td_result_t                 exp_res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tdav_in_if  upd_ch ();
    tdav_out_if res_ch ();

    // shadow of the value table and the configuration registers
    logic signed [VALUE_W-1:0] q_shadow [0:TBL_STATES*TBL_ACTIONS-1];
    logic                      mode_cfg;
    logic [CFG_W-1:0]          lr_cfg;
    logic [CFG_W-1:0]          disc_cfg;
    logic signed [VALUE_W-1:0] init_cfg;

    td_result_t pending_results [$];
    stim_row_t  dir_rows [$];
    int         mismatch_count;
    int         gap_pct;
    int         hold_req;
    int         hold_left;
    int         cycle_count;

    td_action_value_table_update_unit #(
        .STATES  (TBL_STATES),
        .ACTIONS (TBL_ACTIONS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (upd_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // round to nearest of x / 2^16, ties toward plus infinity
    function automatic longint round_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // compute the expected result of one transfer and update the shadow table
    function automatic td_result_t predict_td_update(input td_item_t it);
        td_result_t r;
        longint     old_v;
        longint     boot;
        longint     disc;
        longint     td_v;
        longint     step;
        longint     nv;
        int         p_idx;
        int         n_base;
        if (it.op == OP_CLEAR)
        begin
            foreach (q_shadow[i])
                q_shadow[i] = init_cfg;
            r.nv = init_cfg;
            r.td = '0;
            return r;
        end
        p_idx  = (int'(it.ps) % TBL_STATES) * TBL_ACTIONS + int'(it.pa) % TBL_ACTIONS;
        n_base = (int'(it.ns) % TBL_STATES) * TBL_ACTIONS;
        old_v  = longint'(q_shadow[p_idx]);
        // bootstrap: next pair in SARSA, best action of next state otherwise
        if (mode_cfg == MODE_SARSA)
            boot = longint'(q_shadow[n_base + int'(it.na) % TBL_ACTIONS]);
        else
        begin
            boot = longint'(q_shadow[n_base]);
            for (int a = 1; a < TBL_ACTIONS; a++)
                if (longint'(q_shadow[n_base + a]) > boot)
                    boot = longint'(q_shadow[n_base + a]);
        end
        disc = round_q16(longint'(disc_cfg) * boot);
        td_v = clamp(longint'($signed(it.reward)) + disc - old_v, -65536, 65535);
        step = round_q16(longint'(lr_cfg) * td_v);
        nv   = clamp(old_v + step, -32768, 32767);
        q_shadow[p_idx] = nv[VALUE_W-1:0];
        r.nv = nv[VALUE_W-1:0];
        r.td = td_v[TD_W-1:0];
        return r;
    endfunction

    function automatic void add_item_row(input logic op, input int ps, input int pa,
                                         input int rw, input int ns, input int na,
                                         input logic has_exp, input int e_nv, input int e_td);
        stim_row_t r;
        r            = '0;
        r.kind       = ROW_ITEM;
        r.it.op      = op;
        r.it.ps      = ps[STATE_W-1:0];
        r.it.pa      = pa[ACTION_W-1:0];
        r.it.reward  = rw[VALUE_W-1:0];
        r.it.ns      = ns[STATE_W-1:0];
        r.it.na      = na[ACTION_W-1:0];
        r.has_exp    = has_exp;
        r.exp_res.nv = e_nv[VALUE_W-1:0];
        r.exp_res.td = e_td[TD_W-1:0];
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        dir_rows.push_back(r);
    endfunction

    function automatic td_item_t random_item();
        td_item_t it;
        it.op = ($urandom_range(0, 99) < 2) ? OP_CLEAR : OP_UPDATE;
        // keep most traffic on a few hot states so values build up
        if ($urandom_range(0, 99) < 60)
        begin
            it.ps = STATE_W'($urandom_range(0, 3));
            it.ns = STATE_W'($urandom_range(0, 3));
        end
        else
        begin
            it.ps = STATE_W'($urandom);
            it.ns = STATE_W'($urandom);
        end
        it.pa = ACTION_W'($urandom);
        it.na = ACTION_W'($urandom);
        case ($urandom_range(0, 9))
            0:       it.reward = 16'sh7FFF;
            1:       it.reward = 16'sh8000;
            2, 3, 4: it.reward = VALUE_W'($urandom_range(0, 2047) - 1024);
            default: it.reward = VALUE_W'($urandom);
        endcase
        // sometimes read and write the same pair
        if ($urandom_range(0, 9) == 0)
        begin
            it.ns = it.ps;
            it.na = it.pa;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // offer one item, wait for the transfer, then queue its expected result
    task automatic send_item(input td_item_t it, input logic has_exp, input td_result_t e);
        td_result_t pred;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            upd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        upd_ch.valid       <= 1'b1;
        upd_ch.op          <= it.op;
        upd_ch.prev_state  <= it.ps;
        upd_ch.prev_action <= it.pa;
        upd_ch.reward      <= it.reward;
        upd_ch.next_state  <= it.ns;
        upd_ch.next_action <= it.na;
        @(posedge clk);
        while (!upd_ch.ready)
            @(posedge clk);
        pred = predict_td_update(it);
        if (has_exp)
            pred = e;
        pending_results.push_back(pred);
    endtask

    // write one register once the block has drained
    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        upd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:       mode_cfg = val[0];
            CFG_LEARN_RATE: lr_cfg   = val;
            CFG_DISCOUNT:   disc_cfg = val;
            CFG_INIT_VALUE: init_cfg = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // result side: check each transfer, then drive ready for the next edge
    initial
    begin
        td_result_t e;
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result nv=%0d td=%0d",
                                    res_ch.new_value, res_ch.td_error));
                else
                begin
                    e = pending_results.pop_front();
                    if (res_ch.new_value !== e.nv)
                        report_mismatch($sformatf("new_value %0d, want %0d",
                                        res_ch.new_value, e.nv));
                    if (res_ch.td_error !== e.td)
                        report_mismatch($sformatf("td_error %0d, want %0d",
                                        res_ch.td_error, e.td));
                end
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left = hold_req;
                hold_req  = 0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= gap_pct);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("td_action_value_table_update_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        td_result_t no_exp;
        logic       mode_v;
        logic [CFG_W-1:0] lr_v;
        logic [CFG_W-1:0] disc_v;
        logic [CFG_W-1:0] init_v;

        // drive every input to a known value
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        upd_ch.valid       = 1'b0;
        upd_ch.op          = OP_UPDATE;
        upd_ch.prev_state  = '0;
        upd_ch.prev_action = '0;
        upd_ch.reward      = '0;
        upd_ch.next_state  = '0;
        upd_ch.next_action = '0;
        no_exp             = '0;
        mismatch_count     = 0;
        gap_pct            = 7;
        hold_req           = 0;

        foreach (q_shadow[i])
            q_shadow[i] = '0;
        mode_cfg = MODE_QLEARN;
        lr_cfg   = LEARN_RATE_RST;
        disc_cfg = DISCOUNT_RST;
        init_cfg = '0;

        // directed rows: op, prev state/action, reward, next state/action, typed result
        add_item_row(OP_UPDATE,   0, 0,      0,   0, 0, 1'b1,      0, 0);
        add_item_row(OP_UPDATE, 255, 7,  32767, 255, 7, 1'b0,      0, 0);
        add_item_row(OP_UPDATE,   0, 7, -32768, 255, 0, 1'b0,      0, 0);
        add_item_row(OP_UPDATE, 170, 5,  21845,  85, 2, 1'b0,      0, 0);
        add_item_row(OP_UPDATE,  85, 2, -21846, 170, 5, 1'b0,      0, 0);
        add_item_row(OP_UPDATE,  10, 3,    256,  10, 3, 1'b0,      0, 0);
        add_cfg_row(CFG_LEARN_RATE, 16'hFFFF);
        add_cfg_row(CFG_DISCOUNT,   16'h0000);
        add_cfg_row(CFG_INIT_VALUE, 16'h8000);
        add_item_row(OP_CLEAR,    0, 0,      0,   0, 0, 1'b1, -32768, 0);
        // TD error lands exactly on its upper bound
        add_item_row(OP_UPDATE,   9, 0,  32767, 200, 0, 1'b0,      0, 0);
        add_cfg_row(CFG_DISCOUNT,   16'hFFFF);
        // TD error and new value saturate low
        add_item_row(OP_UPDATE,   9, 0, -32768, 200, 0, 1'b0,      0, 0);
        add_item_row(OP_UPDATE,   9, 0,  32767, 200, 0, 1'b0,      0, 0);
        add_cfg_row(CFG_MODE, {15'd0, MODE_SARSA});
        // next pair equals the updated pair
        add_item_row(OP_UPDATE,   9, 0,    100,   9, 0, 1'b0,      0, 0);
        add_item_row(OP_UPDATE,   9, 1,     -5,   9, 0, 1'b0,      0, 0);
        add_cfg_row(CFG_INIT_VALUE, 16'h7FFF);
        add_item_row(OP_CLEAR,    0, 0,      0,   0, 0, 1'b1,  32767, 0);
        add_item_row(OP_UPDATE,   3, 4,  32767,   3, 4, 1'b0,      0, 0);
        add_cfg_row(CFG_MODE, {15'd0, MODE_QLEARN});
        add_cfg_row(CFG_LEARN_RATE, 16'h0000);
        add_item_row(OP_UPDATE,   3, 4, -32768, 100, 6, 1'b0,      0, 0);
        add_cfg_row(CFG_INIT_VALUE, 16'h0000);
        add_item_row(OP_CLEAR,    0, 0,      0,   0, 0, 1'b1,      0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        foreach (dir_rows[k])
            if (dir_rows[k].kind == ROW_CFG)
                apply_cfg(dir_rows[k].cfg_idx, dir_rows[k].cfg_val);
            else
                send_item(dir_rows[k].it, dir_rows[k].has_exp, dir_rows[k].exp_res);

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    mode_v = MODE_QLEARN;
                    lr_v   = 16'hFFFF;
                    disc_v = 16'hFFFF;
                    init_v = CFG_W'($urandom);
                end
                1:
                begin
                    mode_v = MODE_SARSA;
                    lr_v   = 16'h0000;
                    disc_v = 16'h0000;
                    init_v = 16'h8000;
                end
                2:
                begin
                    mode_v = MODE_SARSA;
                    lr_v   = 16'h8000;
                    disc_v = 16'hFFFF;
                    init_v = 16'h7FFF;
                end
                default:
                begin
                    mode_v = 1'($urandom);
                    lr_v   = CFG_W'($urandom);
                    disc_v = CFG_W'($urandom);
                    init_v = CFG_W'($urandom_range(0, 2047) - 1024);
                end
            endcase
            apply_cfg(CFG_MODE, {15'd0, mode_v});
            apply_cfg(CFG_LEARN_RATE, lr_v);
            apply_cfg(CFG_DISCOUNT, disc_v);
            apply_cfg(CFG_INIT_VALUE, init_v);
            // no idling at all through one phase
            gap_pct = (ph == 2) ? 0 : 7;
            // hold off the result side long enough to back up the input
            if (ph == 3)
                hold_req = 400;
            send_item('{op: OP_CLEAR, default: '0}, 1'b0, no_exp);
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, no_exp);
        end

        // drain and let any stray result show up
        upd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TBL_ACTIONS + 30) @(posedge clk);
        if (mismatch_count == 0)
            $display("td_action_value_table_update_unit_tb: done, clean");
        else
            $display("td_action_value_table_update_unit_tb: done, errors");
        $finish;
    end

endmodule
